### rtl/core/i2c_target_byte_fifo_assert.svh
// ----------------------------------------------------------------------------
// i2c_target_byte_fifo assertion macros
// Shared property forms for the checker of the I2C target byte buffer.
// ----------------------------------------------------------------------------
`ifndef I2C_TARGET_BYTE_FIFO_ASSERT_SVH
`define I2C_TARGET_BYTE_FIFO_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2CTBF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2ctbf: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted
`define I2CTBF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2ctbf: next-cycle property failed");

`endif

### rtl/core/i2ctbf_pkg.sv
// ----------------------------------------------------------------------------
// i2ctbf_pkg
// Types and constants shared by the I2C target byte buffer modules.
// ----------------------------------------------------------------------------
package i2ctbf_pkg;

    // Item kinds on the input tuser field
    typedef enum logic [2:0] {
        REQ_WR_BYTE = 3'd0,
        REQ_RD_BYTE = 3'd1,
        REQ_ADDR    = 3'd2,
        REQ_STOP    = 3'd3,
        REQ_COLL    = 3'd4,
        REQ_TX_PUSH = 3'd5,
        REQ_RX_POP  = 3'd6
    } req_t;

    // Command back to the bus engine
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_DONE = 2'd2
    } bus_cmd_t;

    // Per-item status code
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TX_FULL  = 2'd1,
        ST_RX_EMPTY = 2'd2,
        ST_TX_EMPTY = 2'd3
    } status_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOAD = 1'b1
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;     // accepted item: update indices, access stores
        logic load;     // move the finished result into the output register
    } ctl_cmd_t;

    localparam int  ByteW     = 8;
    localparam int  AddrW     = 7;
    localparam int  OutW      = 24;
    localparam logic [AddrW-1:0] AddrMin  = 7'h08;
    localparam logic [AddrW-1:0] AddrMax  = 7'h77;
    localparam logic [ByteW-1:0] FillByte = 8'hFF;

endpackage

### rtl/core/i2ctbf_ctrl.sv
// ----------------------------------------------------------------------------
// i2ctbf_ctrl
// Controller: accepts one item, then hands its result to the output register.
// ----------------------------------------------------------------------------
module i2ctbf_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output i2ctbf_pkg::ctl_cmd_t  cmd
);

    i2ctbf_pkg::ctrl_state_t state_reg;
    i2ctbf_pkg::ctrl_state_t state_next;
    logic                    out_vld_reg;
    logic                    out_vld_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= i2ctbf_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load     = 1'b0;
        out_vld_next = out_vld_reg && !m_tready;
        unique case (state_reg)
            i2ctbf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = i2ctbf_pkg::ST_LOAD;
                end
            end
            i2ctbf_pkg::ST_LOAD:
            begin
                // hold until the output register is free or being drained
                if (!out_vld_reg || m_tready)
                begin
                    cmd.load     = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = i2ctbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = i2ctbf_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_vld_reg;

endmodule

### rtl/core/i2ctbf_dp.sv
// ----------------------------------------------------------------------------
// i2ctbf_dp
// Datapath: receive and transmit rings, address register, result register.
// ----------------------------------------------------------------------------
module i2ctbf_dp
#(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  i2ctbf_pkg::ctl_cmd_t                  cmd,
    input  i2ctbf_pkg::req_t                      req_type,
    input  logic [i2ctbf_pkg::ByteW-1:0]          data_byte,
    input  logic                                  cfg_we,
    input  logic [i2ctbf_pkg::AddrW-1:0]          cfg_wdata,
    output logic [i2ctbf_pkg::OutW-1:0]           out_data
);

    localparam int RxAw = $clog2(RX_DEPTH);
    localparam int TxAw = $clog2(TX_DEPTH);
    localparam logic [RxAw-1:0] RxLast = RxAw'(RX_DEPTH - 1);
    localparam logic [TxAw-1:0] TxLast = TxAw'(TX_DEPTH - 1);

    // ring storage with per-entry valid bits (unwritten entries read as zero)
    logic [i2ctbf_pkg::ByteW-1:0] rx_mem [RX_DEPTH];
    logic [i2ctbf_pkg::ByteW-1:0] tx_mem [TX_DEPTH];
    logic [RX_DEPTH-1:0]          rx_vld_reg;
    logic [TX_DEPTH-1:0]          tx_vld_reg;

    logic [RxAw-1:0] rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    logic [TxAw-1:0] tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    logic [RxAw-1:0] rx_wr_inc, rx_rd_inc, rx_raddr;
    logic [TxAw-1:0] tx_wr_inc, tx_rd_inc;
    logic            rx_we, tx_we;
    logic            rx_empty, tx_empty;

    logic [i2ctbf_pkg::AddrW-1:0] own_addr_reg;
    i2ctbf_pkg::req_t             req_reg;
    i2ctbf_pkg::status_t          status_reg, status_next;
    logic                         rx_ne_reg;
    logic [i2ctbf_pkg::ByteW-1:0] rx_rdata_reg, tx_rdata_reg;
    logic                         rx_rvld_reg, tx_rvld_reg;
    logic [i2ctbf_pkg::OutW-1:0]  out_data_reg;

    logic [i2ctbf_pkg::ByteW-1:0] bus_data;
    logic [i2ctbf_pkg::ByteW-1:0] cpu_data;
    i2ctbf_pkg::bus_cmd_t         bus_cmd;
    logic                         addr_valid;

    // Wrapping increments
    assign rx_wr_inc = (rx_wr_reg == RxLast) ? '0 : rx_wr_reg + RxAw'(1);
    assign rx_rd_inc = (rx_rd_reg == RxLast) ? '0 : rx_rd_reg + RxAw'(1);
    assign tx_wr_inc = (tx_wr_reg == TxLast) ? '0 : tx_wr_reg + TxAw'(1);
    assign tx_rd_inc = (tx_rd_reg == TxLast) ? '0 : tx_rd_reg + TxAw'(1);
    assign rx_empty  = (rx_wr_reg == rx_rd_reg);
    assign tx_empty  = (tx_wr_reg == tx_rd_reg);

    // Decode the accepted item
    always_comb
    begin
        rx_wr_next  = rx_wr_reg;
        rx_rd_next  = rx_rd_reg;
        tx_wr_next  = tx_wr_reg;
        tx_rd_next  = tx_rd_reg;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        rx_raddr    = rx_rd_reg;
        status_next = i2ctbf_pkg::ST_OK;
        if (cmd.exec)
        begin
            unique case (req_type)
                i2ctbf_pkg::REQ_WR_BYTE:
                begin
                    // no overflow check: write index may catch the read index
                    rx_we      = 1'b1;
                    rx_wr_next = rx_wr_inc;
                end
                i2ctbf_pkg::REQ_RD_BYTE:
                begin
                    if (tx_empty)
                        status_next = i2ctbf_pkg::ST_TX_EMPTY;
                    else
                        tx_rd_next = tx_rd_inc;
                end
                i2ctbf_pkg::REQ_TX_PUSH:
                begin
                    if (tx_wr_inc == tx_rd_reg)
                        status_next = i2ctbf_pkg::ST_TX_FULL;
                    else
                    begin
                        tx_we      = 1'b1;
                        tx_wr_next = tx_wr_inc;
                    end
                end
                i2ctbf_pkg::REQ_RX_POP:
                begin
                    // empty pop returns the entry at the tail, index holds
                    if (rx_empty)
                        status_next = i2ctbf_pkg::ST_RX_EMPTY;
                    else
                    begin
                        rx_rd_next = rx_rd_inc;
                        rx_raddr   = rx_rd_inc;
                    end
                end
                default:
                begin
                    status_next = i2ctbf_pkg::ST_OK;
                end
            endcase
        end
    end

    // Control registers: indices, valid bits, address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_reg    <= '0;
            rx_rd_reg    <= '0;
            tx_wr_reg    <= '0;
            tx_rd_reg    <= '0;
            rx_vld_reg   <= '0;
            tx_vld_reg   <= '0;
            own_addr_reg <= '0;
        end
        else
        begin
            rx_wr_reg <= rx_wr_next;
            rx_rd_reg <= rx_rd_next;
            tx_wr_reg <= tx_wr_next;
            tx_rd_reg <= tx_rd_next;
            if (rx_we)
                rx_vld_reg[rx_wr_inc] <= 1'b1;
            if (tx_we)
                tx_vld_reg[tx_wr_inc] <= 1'b1;
            if (cfg_we)
                own_addr_reg <= cfg_wdata;
        end
    end

    // Receive ring memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_mem[rx_wr_inc] <= data_byte;
        if (cmd.exec)
        begin
            rx_rdata_reg <= rx_mem[rx_raddr];
            rx_rvld_reg  <= rx_vld_reg[rx_raddr];
        end
    end

    // Transmit ring memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (tx_we)
            tx_mem[tx_wr_inc] <= data_byte;
        if (cmd.exec)
        begin
            tx_rdata_reg <= tx_mem[tx_rd_inc];
            tx_rvld_reg  <= tx_vld_reg[tx_rd_inc];
        end
    end

    // Capture per-item result pieces
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            req_reg    <= req_type;
            status_reg <= status_next;
            rx_ne_reg  <= (rx_wr_next != rx_rd_next);
        end
    end

    // Format the result fields
    always_comb
    begin
        bus_data = '0;
        cpu_data = '0;
        bus_cmd  = i2ctbf_pkg::CMD_NONE;
        case (req_reg)
            i2ctbf_pkg::REQ_WR_BYTE,
            i2ctbf_pkg::REQ_ADDR:
            begin
                bus_cmd = i2ctbf_pkg::CMD_ACK;
            end
            i2ctbf_pkg::REQ_RD_BYTE:
            begin
                bus_cmd = i2ctbf_pkg::CMD_ACK;
                if (status_reg == i2ctbf_pkg::ST_TX_EMPTY)
                    bus_data = i2ctbf_pkg::FillByte;
                else if (tx_rvld_reg)
                    bus_data = tx_rdata_reg;
            end
            i2ctbf_pkg::REQ_STOP,
            i2ctbf_pkg::REQ_COLL:
            begin
                bus_cmd = i2ctbf_pkg::CMD_DONE;
            end
            i2ctbf_pkg::REQ_RX_POP:
            begin
                if (rx_rvld_reg)
                    cpu_data = rx_rdata_reg;
            end
            default:
            begin
                bus_cmd = i2ctbf_pkg::CMD_NONE;
            end
        endcase
    end

    assign addr_valid = (own_addr_reg >= i2ctbf_pkg::AddrMin) &&
                        (own_addr_reg <= i2ctbf_pkg::AddrMax);

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            out_data_reg <= {2'b00, addr_valid, status_reg, rx_ne_reg,
                             cpu_data, bus_cmd, bus_data};
    end

    assign out_data = out_data_reg;

endmodule

### rtl/core/i2c_target_byte_fifo.sv
// ----------------------------------------------------------------------------
// i2c_target_byte_fifo
// Target-side I2C byte buffering: receive and transmit rings serving bus
// events and processor accesses, one result item per input item.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: data_byte; tuser: req_type
//  m_*     | out | m_tvalid/m_tready  | tdata: result fields (see port)
//  cfg_*   | in  | cfg_we             | cfg_wdata: own_address
//
//  An accepted item is read from the ring memories into registered result
//  pieces, then loaded into the output register; the controller takes no new
//  item until that load is done, so items are never overlapped.
//  A waiting result does not block the next item; a stalled m side holds the
//  controller after its next item. Reset clears indices and entry valid bits
//  at once, with no clearing pass.
// ----------------------------------------------------------------------------
module i2c_target_byte_fifo
#(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [2:0]  s_tuser,    // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] bus_data, [9:8] bus_command,
                                    // [17:10] cpu_data, [18] rx_not_empty,
                                    // [20:19] status, [21] address_valid
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata   // [6:0] own_address
);

    i2ctbf_pkg::ctl_cmd_t cmd;

    i2ctbf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    i2ctbf_dp #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_type  (i2ctbf_pkg::req_t'(s_tuser)),
        .data_byte (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_data  (m_tdata)
    );

endmodule

### rtl/core/i2ctbf_checker.sv
// ----------------------------------------------------------------------------
// i2ctbf_checker
// Port-level checks for the I2C target byte buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_target_byte_fifo_assert.svh"

module i2ctbf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result holds its payload
    `I2CTBF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one item at a time: no accept in the cycle after an accept
    `I2CTBF_ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // bus command never carries the unused code
    `I2CTBF_ASSERT_IMPLY(a_cmd_code, clk, rst_n, m_tvalid, m_tdata[9:8] != 2'd3)

    // transmit-empty status drives the filler byte
    `I2CTBF_ASSERT_IMPLY(a_fill_byte, clk, rst_n, m_tvalid && (m_tdata[20:19] == i2ctbf_pkg::ST_TX_EMPTY), m_tdata[7:0] == i2ctbf_pkg::FillByte)

endmodule

bind i2c_target_byte_fifo i2ctbf_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
